/* rtl/aar_pkg.sv */
package aar_pkg;

  localparam int FRAC_BITS_DEF  = 14;
  localparam int TRIG_STEPS_DEF = 16;

  // angle scale to 2^-32 turn units
  localparam logic [29:0] K_RAD = 30'd683565276;
  localparam logic [29:0] K_DEG = 30'd11930465;

  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [34:0] ONE_Q30  = 35'sd1073741824;

  // unit vector latency: square sum, 31 root steps, 31 divide steps, sign
  localparam int UV_LAT = 64;

  typedef logic signed [33:0] trig_t;
  typedef logic signed [31:0] unit_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  function automatic logic [31:0] atan_q32(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/aar_cordic.sv */
module aar_cordic import aar_pkg::*; #(
  parameter int TRIG_STEPS = TRIG_STEPS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] angle,
  input  logic               deg,
  output trig_t              cos_q30,
  output trig_t              sin_q30
);

  localparam int NSTEP = (TRIG_STEPS < 32) ? TRIG_STEPS : 32;

  logic [29:0]        kk;
  logic signed [62:0] prod_w;
  logic [47:0]        prod;
  logic [47:0]        rnd;
  logic [31:0]        phase;
  logic [31:0]        qt;
  logic [31:0]        resid;

  assign kk     = deg ? K_DEG : K_RAD;
  assign prod_w = angle * $signed({1'b0, kk});

  always_ff @(posedge clk) begin
    prod <= prod_w[47:0];
  end

  // quadrant fold: residual lands in [-1/8, 1/8) turn
  assign rnd   = prod + 48'h8000;
  assign phase = rnd[47:16];
  assign qt    = phase + 32'h2000_0000;
  assign resid = phase - {qt[31:30], 30'b0};

  trig_t       xr [1:NSTEP];
  trig_t       yr [1:NSTEP];
  trig_t       zr [1:NSTEP];
  logic [1:0]  qr [1:NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    trig_t      xi, yi, zi, dx, dy, at;
    logic [1:0] qi;
    if (i == 0) begin : g_seed
      assign xi = INV_GAIN;
      assign yi = '0;
      assign zi = 34'(signed'(resid));
      assign qi = qt[31:30];
    end else begin : g_prev
      assign xi = xr[i];
      assign yi = yr[i];
      assign zi = zr[i];
      assign qi = qr[i];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = signed'({2'b00, atan_q32(i)});
    always_ff @(posedge clk) begin
      if (!zi[33]) begin
        xr[i+1] <= xi - dx;
        yr[i+1] <= yi + dy;
        zr[i+1] <= zi - at;
      end else begin
        xr[i+1] <= xi + dx;
        yr[i+1] <= yi - dy;
        zr[i+1] <= zi + at;
      end
      qr[i+1] <= qi;
    end
  end

  always_ff @(posedge clk) begin
    case (qr[NSTEP])
      2'd0: begin
        cos_q30 <= xr[NSTEP];
        sin_q30 <= yr[NSTEP];
      end
      2'd1: begin
        cos_q30 <= -yr[NSTEP];
        sin_q30 <= xr[NSTEP];
      end
      2'd2: begin
        cos_q30 <= -xr[NSTEP];
        sin_q30 <= -yr[NSTEP];
      end
      default: begin
        cos_q30 <= yr[NSTEP];
        sin_q30 <= -xr[NSTEP];
      end
    endcase
  end

endmodule

/* rtl/aar_unitvec.sv */
module aar_unitvec import aar_pkg::*; (
  input  logic  clk,
  input  axis_t axis,
  output unit_t ux,
  output unit_t uy,
  output unit_t uz,
  output logic  zero
);

  axis_t       cp   [1:63];
  logic [31:0] l2p  [1:32];
  logic [32:0] remp [1:32];
  logic [30:0] rootp[1:32];

  logic signed [31:0] sqx, sqy, sqz;
  assign sqx = axis.x * axis.x;
  assign sqy = axis.y * axis.y;
  assign sqz = axis.z * axis.z;

  always_ff @(posedge clk) begin
    cp[1]    <= axis;
    l2p[1]   <= $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
    remp[1]  <= '0;
    rootp[1] <= '0;
    for (int i = 2; i <= 63; i++) cp[i] <= cp[i-1];
  end

  // square root of l2 * 2^30, one result bit per stage
  for (genvar k = 0; k < 31; k++) begin : g_sqrt
    logic [61:0] nn;
    logic [34:0] rsh;
    logic [34:0] trial;
    assign nn    = {l2p[k+1], 30'b0};
    assign rsh   = {remp[k+1], nn[2*(30-k) +: 2]};
    assign trial = {2'b00, rootp[k+1], 2'b01};
    always_ff @(posedge clk) begin
      l2p[k+2] <= l2p[k+1];
      if (rsh >= trial) begin
        remp[k+2]  <= 33'(rsh - trial);
        rootp[k+2] <= {rootp[k+1][29:0], 1'b1};
      end else begin
        remp[k+2]  <= rsh[32:0];
        rootp[k+2] <= {rootp[k+1][29:0], 1'b0};
      end
    end
  end

  // |v| * 2^45 + S/2 over S, one quotient bit per stage
  logic [30:0] dsr [1:31];
  logic [30:0] drr [3][1:31];
  logic [30:0] dqr [3][1:31];
  logic [15:0] mag [3];

  function automatic logic [15:0] axis_abs(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : v;
    return r;
  endfunction

  always_comb begin
    mag[0] = axis_abs(cp[32].x);
    mag[1] = axis_abs(cp[32].y);
    mag[2] = axis_abs(cp[32].z);
  end

  for (genvar m = 0; m < 31; m++) begin : g_div
    logic [30:0] si;
    logic [30:0] hh;
    assign si = (m == 0) ? rootp[32] : dsr[(m == 0) ? 1 : m];
    assign hh = {1'b0, si[30:1]};
    always_ff @(posedge clk) begin
      dsr[m+1] <= si;
    end
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [30:0] ri, qi;
      logic [31:0] r2;
      if (m == 0) begin : g_seed
        assign ri = {1'b0, mag[c], 14'b0};
        assign qi = '0;
      end else begin : g_prev
        assign ri = drr[c][m];
        assign qi = dqr[c][m];
      end
      assign r2 = {ri, hh[30-m]};
      always_ff @(posedge clk) begin
        if (r2 >= {1'b0, si}) begin
          drr[c][m+1] <= 31'(r2 - {1'b0, si});
          dqr[c][m+1] <= {qi[29:0], 1'b1};
        end else begin
          drr[c][m+1] <= r2[30:0];
          dqr[c][m+1] <= {qi[29:0], 1'b0};
        end
      end
    end
  end

  function automatic unit_t signed_q(input logic [30:0] q, input logic neg,
                                     input logic z);
    unit_t r;
    r = signed'({1'b0, q});
    if (z) r = '0;
    else if (neg) r = -r;
    return r;
  endfunction

  logic zc;
  assign zc = (cp[63] == '0);

  always_ff @(posedge clk) begin
    ux   <= signed_q(dqr[0][31], cp[63].x[15], zc);
    uy   <= signed_q(dqr[1][31], cp[63].y[15], zc);
    uz   <= signed_q(dqr[2][31], cp[63].z[15], zc);
    zero <= zc;
  end

endmodule

/* rtl/axis_angle_rotation_matrix.sv */
// Channel   Signals                                   Direction  Transfer
// input     start, busy, axis_x/y/z, turn_angle       in         start & !busy
// result    done, m00..m22, axis_zero                 out        done (one cycle)
// config    psel, penable, pwrite, paddr, pwdata,     in/out     psel&penable&pwrite
//           prdata, pready
//
// Fully pipelined: one item per cycle. Latency is set by the unit-vector
// path (31 square-root stages, 31 divide stages); sine/cosine runs beside
// it and is delayed to match.
// Synchronous active-high reset clears the valid chain and the config bit.
// busy is always low and the receiver cannot stall, so nothing is held.
module axis_angle_rotation_matrix import aar_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TRIG_STEPS = TRIG_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] turn_angle,
  output logic               done,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic               axis_zero,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NSTEP   = (TRIG_STEPS < 32) ? TRIG_STEPS : 32;
  localparam int TRIG_LAT = NSTEP + 2;
  localparam int DLY     = UV_LAT - TRIG_LAT;
  localparam int LAT     = UV_LAT + 3;
  localparam int SH      = 30 - FRAC_BITS;
  localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
  localparam logic signed [35:0] LIM = 36'sd1 <<< FRAC_BITS;

  // ---------------- config register ----------------
  logic deg;
  always_ff @(posedge clk) begin
    if (rst) begin
      deg <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      deg <= pwdata[0];
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, deg};
  assign busy   = 1'b0;

  // ---------------- valid chain ----------------
  logic vld [1:LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[1] <= start && !busy;
      for (int i = 2; i <= LAT; i++) vld[i] <= vld[i-1];
    end
  end
  assign done = vld[LAT];

  // ---------------- sine / cosine ----------------
  trig_t cos_c, sin_c;
  aar_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cordic (
    .clk     (clk),
    .angle   (turn_angle),
    .deg     (deg),
    .cos_q30 (cos_c),
    .sin_q30 (sin_c)
  );

  trig_t cdl [1:DLY];
  trig_t sdl [1:DLY];
  always_ff @(posedge clk) begin
    cdl[1] <= cos_c;
    sdl[1] <= sin_c;
    for (int i = 2; i <= DLY; i++) begin
      cdl[i] <= cdl[i-1];
      sdl[i] <= sdl[i-1];
    end
  end

  // ---------------- unit axis ----------------
  unit_t ux, uy, uz;
  logic  uzero;
  aar_unitvec u_unitvec (
    .clk  (clk),
    .axis ('{x: axis_x, y: axis_y, z: axis_z}),
    .ux   (ux),
    .uy   (uy),
    .uz   (uz),
    .zero (uzero)
  );

  // ---------------- products ----------------
  function automatic logic signed [32:0] mul_uu(input unit_t a, input unit_t b);
    logic signed [63:0] p;
    p = a * b;
    return 33'(p >>> 30);
  endfunction

  function automatic logic signed [33:0] mul_us(input unit_t a, input trig_t b);
    logic signed [65:0] p;
    p = a * b;
    return 34'(p >>> 30);
  endfunction

  function automatic logic signed [33:0] mul_uo(input logic signed [32:0] a,
                                               input logic signed [34:0] b);
    logic signed [67:0] p;
    p = a * b;
    return 34'(p >>> 30);
  endfunction

  // stage 1: u*u, u*s, 1-c
  logic signed [32:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [33:0] sx1, sy1, sz1;
  logic signed [34:0] omc;
  trig_t              c1;
  logic               z1;
  always_ff @(posedge clk) begin
    pxx <= mul_uu(ux, ux);
    pyy <= mul_uu(uy, uy);
    pzz <= mul_uu(uz, uz);
    pxy <= mul_uu(ux, uy);
    pxz <= mul_uu(ux, uz);
    pyz <= mul_uu(uy, uz);
    sx1 <= mul_us(ux, sdl[DLY]);
    sy1 <= mul_us(uy, sdl[DLY]);
    sz1 <= mul_us(uz, sdl[DLY]);
    omc <= ONE_Q30 - 35'(cdl[DLY]);
    c1  <= cdl[DLY];
    z1  <= uzero;
  end

  // stage 2: scale by 1-c
  logic signed [33:0] qxx, qyy, qzz, qxy, qxz, qyz;
  logic signed [33:0] sx2, sy2, sz2;
  trig_t              c2;
  logic               z2;
  always_ff @(posedge clk) begin
    qxx <= mul_uo(pxx, omc);
    qyy <= mul_uo(pyy, omc);
    qzz <= mul_uo(pzz, omc);
    qxy <= mul_uo(pxy, omc);
    qxz <= mul_uo(pxz, omc);
    qyz <= mul_uo(pyz, omc);
    sx2 <= sx1;
    sy2 <= sy1;
    sz2 <= sz1;
    c2  <= c1;
    z2  <= z1;
  end

  // stage 3: sum, round to FRAC_BITS, saturate to +-1
  function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + RND) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[15:0];
  endfunction

  function automatic logic signed [35:0] ext(input logic signed [33:0] v);
    return 36'(v);
  endfunction

  always_ff @(posedge clk) begin
    m00       <= to_out(ext(c2) + ext(qxx));
    m01       <= to_out(ext(qxy) - ext(sz2));
    m02       <= to_out(ext(qxz) + ext(sy2));
    m10       <= to_out(ext(qxy) + ext(sz2));
    m11       <= to_out(ext(c2) + ext(qyy));
    m12       <= to_out(ext(qyz) - ext(sx2));
    m20       <= to_out(ext(qxz) - ext(sy2));
    m21       <= to_out(ext(qyz) + ext(sx2));
    m22       <= to_out(ext(c2) + ext(qzz));
    axis_zero <= z2;
  end

endmodule

/* bench/tb_axis_angle_rotation_matrix.sv */
module tb_axis_angle_rotation_matrix;
  import aar_pkg::*;

  localparam int  ITEMS_PER_PHASE = 270;
  localparam int  DRAIN_CYCLES    = 80;     // longer than the block latency
  localparam int  STALL_LIMIT     = 5000;   // cycles with no transfer at all
  localparam logic [2:0] ADDR_ANGLE_MODE = 3'd0;

  // arctangent of 2^-i in 2^-32 turn units
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  typedef struct {
    axis_t              ax;
    logic signed [31:0] ang;
  } turn_req_t;

  typedef struct {
    logic [15:0] m [9];
    logic        zero;
  } rot_mat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, all known from time zero
  logic               start = 1'b0;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [31:0] turn_angle = '0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;

  logic               busy, done, axis_zero, pready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic [31:0]        prdata;

  axis_angle_rotation_matrix u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .turn_angle(turn_angle),
    .done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
    .m12(m12), .m20(m20), .m21(m21), .m22(m22), .axis_zero(axis_zero),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  turn_req_t pending_q [$];     // items waiting to be driven
  rot_mat_t  matrix_q  [$];     // predicted matrices, oldest first
  bit        degrees_mode = 1'b0;
  int        sender_idle_pct = 0;
  int        err_count = 0;
  int        sent_count = 0;
  int        matrix_count = 0;
  int        zero_axis_count = 0;
  int        quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: Rodrigues matrix from phase-domain CORDIC and normalized axis
  // ---------------------------------------------------------------------------
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // Q30 -> Q1.14 with round half up, saturate to +-1
  function automatic logic [15:0] q30_to_q14(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic longint unit_q30(longint v, logic [63:0] root);
    logic [63:0] mag, quo;
    mag = (v < 0) ? -v : v;
    quo = ((mag << 45) + (root >> 1)) / root;
    return (v < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic rot_mat_t rodrigues(turn_req_t t, bit deg);
    rot_mat_t    res;
    logic [63:0] prod, n, root, bitv, l2;
    logic [31:0] phase, resid, tmp;
    logic [1:0]  quad;
    longint      x, y, z, nx, dx, dy, c, s, omc;
    longint      vx, vy, vz, ux, uy, uz, pxy, pxz, pyz;
    // angle -> 2^-32 turn phase, rounded
    prod  = longint'(t.ang) * (deg ? 64'd11930465 : 64'd683565276);
    prod  = prod + 64'h8000;
    phase = prod[47:16];
    tmp   = phase + 32'h20000000;
    quad  = tmp[31:30];
    resid = phase - {quad, 30'd0};
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        nx = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    omc = 64'sd1073741824 - c;

    // axis normalization: integer sqrt of L2 * 2^30
    vx = t.ax.x; vy = t.ax.y; vz = t.ax.z;
    l2 = vx * vx + vy * vy + vz * vz;
    ux = 0; uy = 0; uz = 0;
    res.zero = (l2 == 0);
    if (!res.zero) begin
      n = l2 << 30;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      ux = unit_q30(vx, root);
      uy = unit_q30(vy, root);
      uz = unit_q30(vz, root);
    end
    pxy = q30_mul(q30_mul(ux, uy), omc);
    pxz = q30_mul(q30_mul(ux, uz), omc);
    pyz = q30_mul(q30_mul(uy, uz), omc);
    res.m[0] = q30_to_q14(c + q30_mul(q30_mul(ux, ux), omc));
    res.m[1] = q30_to_q14(pxy - q30_mul(uz, s));
    res.m[2] = q30_to_q14(pxz + q30_mul(uy, s));
    res.m[3] = q30_to_q14(pxy + q30_mul(uz, s));
    res.m[4] = q30_to_q14(c + q30_mul(q30_mul(uy, uy), omc));
    res.m[5] = q30_to_q14(pyz - q30_mul(ux, s));
    res.m[6] = q30_to_q14(pxz - q30_mul(uy, s));
    res.m[7] = q30_to_q14(pyz + q30_mul(ux, s));
    res.m[8] = q30_to_q14(c + q30_mul(q30_mul(uz, uz), omc));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending items, idles at random; a transfer predicts a matrix
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    turn_req_t nxt;
    if (!rst) begin
      if (start && !busy) begin
        matrix_q.push_back(rodrigues('{ax: '{axis_x, axis_y, axis_z},
                                       ang: turn_angle}, degrees_mode));
        sent_count++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_q.pop_front();
          start      <= 1'b1;
          axis_x     <= nxt.ax.x;
          axis_y     <= nxt.ax.y;
          axis_z     <= nxt.ax.z;
          turn_angle <= nxt.ang;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done strobe is one matrix transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rot_mat_t seen, want;
    if (!rst && done) begin
      seen.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      seen.zero = axis_zero;
      matrix_count++;
      if (axis_zero) zero_axis_count++;
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix transfer m00=%0d", $time, m00);
        err_count++;
      end else begin
        want = matrix_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (seen.m[k] !== want.m[k]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                     $signed(want.m[k]), $signed(seen.m[k]));
            err_count++;
          end
        end
        if (seen.zero !== want.zero) begin
          $display("%0t: axis_zero expected %0b actual %0b", $time,
                   want.zero, seen.zero);
          err_count++;
        end
      end
    end
  end

  // watchdog: any transfer resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d matrices still pending", matrix_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'sd0;
      1: return 16'(int'($urandom_range(0, 14)) - 7);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(int x, int y, int z, logic signed [31:0] a);
    pending_q.push_back('{ax: '{16'(x), 16'(y), 16'(z)}, ang: a});
  endtask

  task automatic add_random(int n);
    int mode;
    logic signed [31:0] a;
    repeat (n) begin
      mode = $urandom_range(9);
      // zero axis now and then, small axes, otherwise zero, small or full range per component
      if (mode == 0) begin
        add_item(0, 0, 0, 32'($urandom));
      end else begin
        if ($urandom_range(2) == 0)
          a = 32'($urandom);                                 // any Q15.16 angle
        else
          a = 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25)); // within +-512
        add_item(rand_comp(mode < 3 ? 1 : $urandom_range(2)),
                 rand_comp(mode < 3 ? 1 : $urandom_range(2)),
                 rand_comp(mode < 3 ? 1 : $urandom_range(2)), a);
      end
    end
  endtask

  // wait for the block to empty out, then settle past its latency
  task automatic drain();
    wait (pending_q.size() == 0 && !start && matrix_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_angle_mode(logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_ANGLE_MODE; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    pwdata <= 32'($urandom);
    degrees_mode = val[0];
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: axis extremes, zero axis, angle extremes, quarter turns
    add_item(32767, 0, 0, 32'sd102944);          // ~pi/2 rad about x
    add_item(0, -32768, 0, 32'sd205887);         // ~pi about -y
    add_item(0, 0, 32767, -32'sd102944);
    add_item(-32768, -32768, -32768, 32'sd0);    // identity
    add_item(32767, 32767, 32767, 32'h7FFFFFFF);
    add_item(-32768, 32767, -1, 32'h80000000);
    add_item(0, 0, 0, 32'sd65536);               // zero axis, 1 rad
    add_item(0, 0, 0, 32'h80000000);
    add_item(1, 0, 0, 32'sd411775);              // ~2*pi
    add_item(1, 1, 1, -32'sd1);
    add_item(-1, 0, 1, 32'sd1);
    add_item(3, 4, 0, 32'sd51472);
    add_item(-21845, 10922, 5461, 32'hFFFF0000);
    drain();

    write_angle_mode(32'h0000_0001);
    add_item(0, 0, 32767, 32'sd90 <<< 16);       // 90 degrees
    add_item(0, 0, 32767, -32'sd180 <<< 16);
    add_item(32767, 0, 0, 32'sd360 <<< 16);
    add_item(0, 0, 0, 32'sd45 <<< 16);
    add_item(-32768, -32768, 32767, 32'h7FFFFFFF);
    add_item(5, -5, 5, 32'h80000000);
    sender_idle_pct = 25;
    add_random(ITEMS_PER_PHASE);
    drain();

    write_angle_mode(32'hFFFF_FFFE);             // upper bits ignored, radians
    sender_idle_pct = 80;
    add_random(ITEMS_PER_PHASE);
    drain();

    write_angle_mode(32'hFFFF_FFFF);
    sender_idle_pct = 0;
    add_random(ITEMS_PER_PHASE / 2);
    drain();
    write_angle_mode(32'h0000_0000);
    add_random(ITEMS_PER_PHASE / 2);
    drain();

    $display("%0d items sent, %0d matrices checked (%0d zero-axis),",
             sent_count, matrix_count, zero_axis_count);
    $display("radian and degree modes, sender idling at 25, 80 and 0 percent");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
